>>> rtl/arpc_pkg.sv
package arpc_pkg;

  localparam logic [31:0] AGE_START = 32'hffff_ffff;

  // Widths of the stream payloads
  localparam int IN_DATA_W  = 80;  // ip_addr, mac_addr
  localparam int OUT_DATA_W = 56;  // found_mac, slot_index, pad
  localparam int IDX_OUT_W  = 3;

  // Program step addresses
  typedef enum logic [1:0] {
    ST_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } step_t;

  // Hold conditions: the step repeats while its condition is true
  typedef enum logic [1:0] {
    C_GO,
    C_IN,
    C_SCAN,
    C_OUT
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  rd;
    logic  commit;
    cond_t cond;
    step_t nxt;
  } cw_t;

  function automatic cw_t ucode(input step_t pc);
    cw_t cw;
    cw = '{accept: 1'b0, rd: 1'b0, commit: 1'b0, cond: C_GO, nxt: ST_WAIT};
    case (pc)
      ST_WAIT:   cw = '{accept: 1'b1, rd: 1'b0, commit: 1'b0, cond: C_IN,   nxt: ST_SCAN};
      ST_SCAN:   cw = '{accept: 1'b0, rd: 1'b1, commit: 1'b0, cond: C_SCAN, nxt: ST_DRAIN};
      ST_DRAIN:  cw = '{accept: 1'b0, rd: 1'b0, commit: 1'b0, cond: C_GO,   nxt: ST_COMMIT};
      ST_COMMIT: cw = '{accept: 1'b0, rd: 1'b0, commit: 1'b1, cond: C_OUT,  nxt: ST_WAIT};
      default:   cw = '{accept: 1'b0, rd: 1'b0, commit: 1'b0, cond: C_GO,   nxt: ST_WAIT};
    endcase
    return cw;
  endfunction

endpackage

>>> rtl/arpc_ram.sv
module arpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/arp_cache_learn_lookup_core.sv
// Each item: accept, then one RAM read per slot, one drain step, and the commit of the result.
// Items go through one at a time, the slot scan running through the single read port.
// A new item is taken while the previous result still waits on the output register.
// Reset (synchronous, rst_n low): per-slot valid bits cleared at once, so every slot reads
// as IP 0, MAC 0, age 0; age counter set to one; no clearing pass.
module arp_cache_learn_lookup_core #(
  parameter int SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [arpc_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] ip_addr, [79:32] mac_addr
  input  logic                            in_tuser,   // [0] action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [arpc_pkg::OUT_DATA_W-1:0] out_tdata,  // [47:0] found_mac, [50:48] slot_index
  output logic                            out_tuser   // [0] hit
);

  import arpc_pkg::*;

  localparam int          IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  step_t pc_r, pc_nxt;
  cw_t   cw;
  logic  hold;

  logic          act_r;
  logic [31:0]   ip_r;
  logic [47:0]   mac_r;
  logic [IW-1:0] idx_r;
  logic [31:0]   age_cnt_r;
  logic          vld_r [SLOTS];

  logic          ev_r;
  logic          ev_vld_r;
  logic [IW-1:0] ev_idx_r;

  logic          m_found_r;
  logic [IW-1:0] m_idx_r;
  logic [47:0]   m_mac_r;
  logic [31:0]   best_age_r;
  logic [IW-1:0] best_idx_r;

  logic          out_valid_r;
  logic          out_hit_r;
  logic [47:0]   out_mac_r;
  logic [2:0]    out_idx_r;

  logic [31:0]   q_ip, q_age, e_ip, e_age;
  logic [47:0]   q_mac, e_mac;
  logic          fire_in, fire_commit, we;
  logic [IW-1:0] tgt;
  logic [47:0]   w_mac;
  logic [IW+IDX_OUT_W-1:0] tgt_ext, hit_ext;

  assign cw = ucode(pc_r);

  always_comb begin
    case (cw.cond)
      C_IN:    hold = !in_tvalid;
      C_SCAN:  hold = (idx_r != LAST);
      C_OUT:   hold = out_valid_r && !out_tready;
      default: hold = 1'b0;
    endcase
    pc_nxt = hold ? pc_r : cw.nxt;
  end

  assign in_tready   = cw.accept;
  assign fire_in     = cw.accept && in_tvalid;
  assign fire_commit = cw.commit && !hold;

  // Unwritten slots read as cleared
  assign e_ip  = ev_vld_r ? q_ip  : 32'd0;
  assign e_mac = ev_vld_r ? q_mac : 48'd0;
  assign e_age = ev_vld_r ? q_age : 32'd0;

  // Lookup hit rewrites the slot with its own IP and MAC, so all three stores stay in step
  assign we      = fire_commit && (!act_r || m_found_r);
  assign tgt     = m_found_r ? m_idx_r : best_idx_r;
  assign w_mac   = act_r ? m_mac_r : mac_r;
  assign tgt_ext = {{IDX_OUT_W{1'b0}}, tgt};
  assign hit_ext = {{IDX_OUT_W{1'b0}}, m_idx_r};

  arpc_ram #(.WIDTH(32), .DEPTH(SLOTS), .AW(IW)) u_ip_ram (
    .clk(clk), .we(we), .waddr(tgt), .wdata(ip_r),
    .re(cw.rd), .raddr(idx_r), .rdata(q_ip)
  );

  arpc_ram #(.WIDTH(48), .DEPTH(SLOTS), .AW(IW)) u_mac_ram (
    .clk(clk), .we(we), .waddr(tgt), .wdata(w_mac),
    .re(cw.rd), .raddr(idx_r), .rdata(q_mac)
  );

  arpc_ram #(.WIDTH(32), .DEPTH(SLOTS), .AW(IW)) u_age_ram (
    .clk(clk), .we(we), .waddr(tgt), .wdata(age_cnt_r),
    .re(cw.rd), .raddr(idx_r), .rdata(q_age)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_WAIT;
      ev_r        <= 1'b0;
      out_valid_r <= 1'b0;
      age_cnt_r   <= 32'd1;
      for (int k = 0; k < SLOTS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      pc_r <= pc_nxt;
      ev_r <= cw.rd;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (fire_commit) begin
        out_valid_r <= 1'b1;
      end
      if (we) begin
        vld_r[tgt] <= 1'b1;
        age_cnt_r  <= age_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in) begin
      act_r      <= in_tuser;
      ip_r       <= in_tdata[31:0];
      mac_r      <= in_tdata[79:32];
      idx_r      <= '0;
      m_found_r  <= 1'b0;
      best_age_r <= AGE_START;
      best_idx_r <= '0;
    end else begin
      if (cw.rd) begin
        idx_r <= idx_r + 1'b1;
      end
      // scan evaluation, one slot behind the read address
      if (ev_r) begin
        if (!m_found_r && e_ip == ip_r) begin
          m_found_r <= 1'b1;
          m_idx_r   <= ev_idx_r;
          m_mac_r   <= e_mac;
        end
        if (e_age < best_age_r) begin
          best_age_r <= e_age;
          best_idx_r <= ev_idx_r;
        end
      end
    end
    ev_idx_r <= idx_r;
    ev_vld_r <= vld_r[idx_r];
    if (fire_commit) begin
      out_hit_r <= m_found_r;
      out_mac_r <= (act_r && m_found_r) ? m_mac_r : 48'd0;
      if (!act_r) begin
        out_idx_r <= tgt_ext[IDX_OUT_W-1:0];
      end else if (m_found_r) begin
        out_idx_r <= hit_ext[IDX_OUT_W-1:0];
      end else begin
        out_idx_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(OUT_DATA_W - 48 - IDX_OUT_W){1'b0}}, out_idx_r, out_mac_r};

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import arpc_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int RAND_ITEMS  = 430;
  localparam int LONG_HOLD   = 120;
  localparam int HOLD_AT     = 150;
  localparam int DRAIN_WAIT  = NUM_SLOTS + 12;

  typedef enum bit {
    ACT_LEARN  = 1'b0,
    ACT_LOOKUP = 1'b1
  } arp_act_t;

  typedef struct {
    arp_act_t    action;
    logic [31:0] ip;
    logic [47:0] mac;
    bit          drain_first;  // sender waits until all results are back
  } arp_req_t;

  typedef struct {
    logic        hit;
    logic [47:0] mac;
    logic [2:0]  idx;
  } arp_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  always #10 clk = ~clk;

  arp_cache_learn_lookup_core #(
    .SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Shadow copy of the cache
  logic [31:0] cache_ip    [NUM_SLOTS];
  logic [47:0] cache_mac   [NUM_SLOTS];
  logic [31:0] cache_stamp [NUM_SLOTS];
  logic [31:0] stamp_ctr;

  arp_req_t  pend_q[$];
  arp_resp_t arp_resp_q[$];
  arp_req_t  in_flight;

  int err_cnt    = 0;
  int learn_cnt  = 0;
  int lookup_cnt = 0;
  int hit_cnt    = 0;
  int beat_cnt   = 0;
  int tx_gap     = 0;
  int rx_stall   = 0;
  bit tx_eager   = 1'b0;
  bit rx_eager   = 1'b0;
  bit long_done  = 1'b0;

  function automatic void clear_cache();
    for (int k = 0; k < NUM_SLOTS; k++) begin
      cache_ip[k]    = '0;
      cache_mac[k]   = '0;
      cache_stamp[k] = '0;
    end
    stamp_ctr = 32'd1;
  endfunction

  function automatic arp_resp_t resolve_arp(arp_req_t req);
    arp_resp_t   r;
    int          match;
    int          target;
    logic [31:0] oldest;
    match = NUM_SLOTS;
    for (int k = NUM_SLOTS - 1; k >= 0; k--)
      if (cache_ip[k] == req.ip) match = k;
    r.hit = (match < NUM_SLOTS);
    r.mac = '0;
    r.idx = '0;
    if (req.action == ACT_LEARN) begin
      target = 0;
      if (r.hit) begin
        target = match;
      end else begin
        // LRU victim: strictly smallest stamp, lowest index on ties
        oldest = AGE_START;
        for (int k = 0; k < NUM_SLOTS; k++)
          if (cache_stamp[k] < oldest) begin
            oldest = cache_stamp[k];
            target = k;
          end
      end
      cache_ip[target]    = req.ip;
      cache_mac[target]   = req.mac;
      cache_stamp[target] = stamp_ctr;
      stamp_ctr           = stamp_ctr + 32'd1;
      r.idx = 3'(target);
    end else if (r.hit) begin
      cache_stamp[match] = stamp_ctr;
      stamp_ctr          = stamp_ctr + 32'd1;
      r.mac = cache_mac[match];
      r.idx = 3'(match);
    end
    return r;
  endfunction

  function automatic void add_req(arp_act_t act, logic [31:0] ip, logic [47:0] mac,
                                  bit drain = 1'b0);
    arp_req_t req;
    req.action      = act;
    req.ip          = ip;
    req.mac         = mac;
    req.drain_first = drain;
    pend_q.push_back(req);
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic void flag_mismatch(string field, logic [47:0] want, logic [47:0] got);
    err_cnt++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endfunction

  // Input driver
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      offer = in_tvalid;
      if (in_tvalid && in_tready) begin
        arp_resp_q.push_back(resolve_arp(in_flight));
        if (in_flight.action == ACT_LEARN) learn_cnt++;
        else lookup_cnt++;
        offer  = 1'b0;
        tx_gap = tx_eager ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 29) == 0) tx_eager = !tx_eager;
      end
      if (!offer && pend_q.size() > 0) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!(pend_q[0].drain_first && arp_resp_q.size() != 0)) begin
          in_flight = pend_q.pop_front();
          in_tdata <= {in_flight.mac, in_flight.ip};
          in_tuser <= in_flight.action;
          offer = 1'b1;
        end
      end
      in_tvalid <= offer;
    end
  end

  // Result monitor and output backpressure
  always @(posedge clk) begin
    arp_resp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (arp_resp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat, expected none, actual hit=%0b tdata=0x%0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = arp_resp_q.pop_front();
          if (out_tuser !== want.hit) flag_mismatch("hit", 48'(want.hit), 48'(out_tuser));
          if (out_tdata[47:0] !== want.mac)
            flag_mismatch("found_mac", want.mac, out_tdata[47:0]);
          if (out_tdata[50:48] !== want.idx)
            flag_mismatch("slot_index", 48'(want.idx), 48'(out_tdata[50:48]));
          if (out_tuser === 1'b1) hit_cnt++;
        end
        beat_cnt++;
        rx_stall = rx_eager ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 29) == 0) rx_eager = !rx_eager;
        if (beat_cnt == HOLD_AT && !long_done) begin
          // long hold so the core backs up and drops in_tready
          rx_stall  = LONG_HOLD;
          long_done = 1'b1;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] ip_pool [12];
    logic [31:0] ip;

    clear_cache();

    // Directed: cleared slots, extremes, fill, LRU eviction, refresh
    add_req(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    add_req(ACT_LOOKUP, 32'hffff_ffff, 48'hffff_ffff_ffff);
    add_req(ACT_LEARN,  32'hffff_ffff, 48'hffff_ffff_ffff);
    add_req(ACT_LOOKUP, 32'hffff_ffff, 48'h0);
    add_req(ACT_LEARN,  32'h0000_0000, 48'h0000_0000_0001);
    add_req(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    for (int k = 1; k <= 7; k++)
      add_req(ACT_LEARN, 32'h0a00_0000 + k, 48'h0200_0000_0000 + k);
    add_req(ACT_LOOKUP, 32'h0a00_0003, 48'h0);
    add_req(ACT_LEARN,  32'hc0a8_0101, 48'h8000_0000_0000);
    add_req(ACT_LEARN,  32'hc0a8_0102, 48'h5555_aaaa_5555);
    add_req(ACT_LEARN,  32'h0a00_0003, 48'haaaa_5555_aaaa);
    add_req(ACT_LOOKUP, 32'h0a00_0003, 48'h1234_5678_9abc);
    add_req(ACT_LOOKUP, 32'h8000_0000, 48'h0);
    add_req(ACT_LOOKUP, 32'hc0a8_0101, 48'h0);
    add_req(ACT_LEARN,  32'h5555_aaaa, 48'h0);

    // Random: mostly addresses from a small pool so hits and reuse are common
    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hffff_ffff;
    for (int k = 2; k < 12; k++) ip_pool[k] = $urandom;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 7) ip = ip_pool[$urandom_range(0, 11)];
      else ip = $urandom;
      add_req($urandom_range(0, 1) ? ACT_LOOKUP : ACT_LEARN, ip, rand_mac(),
              (n == 0) || (n == 260));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_tvalid || arp_resp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (arp_resp_q.size() != 0) begin
      err_cnt++;
      $display("%0t: results outstanding at end, expected 0, actual %0d",
               $time, arp_resp_q.size());
    end

    $display("Covered %0d learns and %0d lookups, %0d results with hit set.",
             learn_cnt, lookup_cnt, hit_cnt);
    $display("Included one long output hold and two full drains of the core.");
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout waiting for results");
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arp_cache_learn_lookup_core.sv
dv/tb_top.sv
